[rtl/dspe_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the shortest path engine.
`default_nettype none
package dspe_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;

    // Field widths
    localparam int VERT_W     = 5;
    localparam int DIST_W     = 16;
    localparam int IN_WGT_W   = 16;
    localparam int VC_W       = 6;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INFINITY     = 1'b1;
    localparam logic [VC_W-1:0]      VC_RESET         = 6'd32;
    localparam logic [DIST_W-1:0]    INF_RESET        = 16'd20000;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic sweep;        // write no-edge at the sweep address, advance
        logic wr_weight;    // store one edge weight from the request
        logic run_start;    // capture source, clear visited and counters
        logic init_wr;      // write initial distance at index, advance
        logic pass_start;   // clear index and found flag
        logic idx_clr;      // clear index
        logic sel_rd;       // read distance at index for the minimum scan
        logic rel_rd;       // read distance and weight at index for relaxing
        logic pick_commit;  // mark picked vertex visited, advance pass
        logic out_rd;       // read distance at index for output
    } dspe_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sweep_end;    // sweep address at the last entry
        logic idx_end;      // index reached the vertex count
        logic pass_end;     // pass count reached the vertex count
        logic pipe_busy;    // a scan read is still being processed
        logic out_busy;     // a result is loading or waiting on the output
        logic found;        // the scan found an unvisited vertex
        logic relax_ok;     // picked vertex found and reachable
    } dspe_sts_t;

endpackage
`default_nettype wire

[rtl/dspe_ctrl.sv]
// Controller state machine of the shortest path engine.
`default_nettype none
module dspe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic              in_kind,
    output logic                   in_ready,
    input  wire dspe_pkg::dspe_sts_t sts,
    output dspe_pkg::dspe_cmd_t    cmd
);
    import dspe_pkg::*;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_INIT     = 4'd2;
    localparam logic [3:0] ST_PASS     = 4'd3;
    localparam logic [3:0] ST_SEL      = 4'd4;
    localparam logic [3:0] ST_PICK     = 4'd5;
    localparam logic [3:0] ST_RELAX    = 4'd6;
    localparam logic [3:0] ST_OUT_RD   = 4'd7;
    localparam logic [3:0] ST_OUT_WAIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Decode next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_kind == KIND_RUN) begin
                        cmd.run_start = 1'b1;
                        state_next    = ST_INIT;
                    end else begin
                        cmd.wr_weight = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                if (sts.idx_end) begin
                    state_next = ST_PASS;
                end else begin
                    cmd.init_wr = 1'b1;
                end
            end
            ST_PASS: begin
                if (sts.pass_end) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_OUT_RD;
                end else begin
                    cmd.pass_start = 1'b1;
                    state_next     = ST_SEL;
                end
            end
            ST_SEL: begin
                if (!sts.idx_end) begin
                    cmd.sel_rd = 1'b1;
                end else if (!sts.pipe_busy) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.pick_commit = 1'b1;
                cmd.idx_clr     = 1'b1;
                state_next      = sts.relax_ok ? ST_RELAX : ST_PASS;
            end
            ST_RELAX: begin
                if (!sts.idx_end) begin
                    cmd.rel_rd = 1'b1;
                end else if (!sts.pipe_busy) begin
                    state_next = ST_PASS;
                end
            end
            ST_OUT_RD: begin
                if (sts.idx_end) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.out_rd = 1'b1;
                    state_next = ST_OUT_WAIT;
                end
            end
            ST_OUT_WAIT: begin
                if (!sts.out_busy) begin
                    state_next = ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state; start with the matrix clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.sweep, cmd.init_wr, cmd.sel_rd, cmd.rel_rd, cmd.out_rd}))
        else $error("dspe_ctrl: more than one memory access command");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_rd |-> !sts.out_busy)
        else $error("dspe_ctrl: output read while a result is pending");
    a_relax_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rel_rd |-> sts.relax_ok)
        else $error("dspe_ctrl: relaxing without a reachable pick");
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (!sts.out_busy && !sts.pipe_busy))
        else $error("dspe_ctrl: request taken while a run is still draining");
`endif

endmodule
`default_nettype wire

[rtl/dspe_datapath.sv]
// Datapath of the shortest path engine: weight matrix, distance table, scan and output.
`default_nettype none
module dspe_datapath #(
    parameter int MAX_VERTICES = dspe_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dspe_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dspe_pkg::dspe_cmd_t               cmd,
    output dspe_pkg::dspe_sts_t                    sts,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0] n_active,
    input  wire logic [dspe_pkg::DIST_W-1:0]       infinity,
    input  wire logic [dspe_pkg::VERT_W-1:0]       wr_row,
    input  wire logic [dspe_pkg::VERT_W-1:0]       wr_col,
    input  wire logic [dspe_pkg::IN_WGT_W-1:0]     wr_weight,
    input  wire logic [dspe_pkg::VERT_W-1:0]       run_source,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [dspe_pkg::VERT_W-1:0]            out_vertex,
    output logic [dspe_pkg::DIST_W-1:0]            out_distance,
    output logic                                   out_last
);
    import dspe_pkg::*;

    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int AW  = 2 * VW;
    localparam int SW  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    // Weight matrix, row-major with a power-of-two row pitch
    logic [WEIGHT_BITS-1:0] wmem [0:(1<<AW)-1];
    // Distance table
    logic [DIST_W-1:0]      dmem [0:MAX_VERTICES-1];

    logic [AW-1:0]           sweep_reg;
    logic [NW-1:0]           idx_reg;
    logic [NW-1:0]           pass_reg;
    logic                    p_sel_reg;
    logic                    p_rel_reg;
    logic                    p_out_reg;
    logic [NW-1:0]           p_idx_reg;
    logic [WEIGHT_BITS-1:0]  w_q_reg;
    logic [DIST_W-1:0]       d_q_reg;
    logic [VW-1:0]           pick_reg;
    logic [DIST_W-1:0]       best_reg;
    logic                    found_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [VERT_W-1:0]       src_reg;
    logic                    out_valid_reg;
    logic [VERT_W-1:0]       out_vertex_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic                    out_last_reg;

    logic [VW-1:0]     idx_v;
    logic [VW-1:0]     p_v;
    logic              row_ok;
    logic [AW-1:0]     wr_addr;
    logic [DIST_W-1:0] init_val;
    logic [SW-1:0]     sum;
    logic              relax_wr;
    logic              sel_take;
    logic              rd_issue;
    logic              p_last;

    assign idx_v    = idx_reg[VW-1:0];
    assign p_v      = p_idx_reg[VW-1:0];
    assign row_ok   = (32'(wr_row) < 32'(MAX_VERTICES)) && (32'(wr_col) < 32'(MAX_VERTICES));
    assign wr_addr  = {VW'(wr_row), VW'(wr_col)};
    assign init_val = (32'(src_reg) == 32'(idx_reg)) ? '0 : infinity;
    assign rd_issue = cmd.sel_rd | cmd.rel_rd | cmd.out_rd;
    assign p_last   = ((NW+1)'(p_idx_reg) + (NW+1)'(1)) == (NW+1)'(n_active);

    // Relax the neighbor whose read just returned
    assign sum      = SW'(best_reg) + SW'(w_q_reg);
    assign relax_wr = p_rel_reg && !visited_reg[p_v]
                      && (SW'(w_q_reg) < SW'(infinity)) && (sum < SW'(d_q_reg));

    // Take a smaller unvisited distance; strict compare keeps the lowest index on a tie
    assign sel_take = p_sel_reg && !visited_reg[p_v] && (!found_reg || d_q_reg < best_reg);

    // Weight matrix write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            wmem[sweep_reg] <= '1;
        end else if (cmd.wr_weight && row_ok) begin
            wmem[wr_addr] <= WEIGHT_BITS'(wr_weight);
        end
        if (rd_issue) begin
            w_q_reg <= wmem[{pick_reg, idx_v}];
        end
    end

    // Distance table write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.init_wr) begin
            dmem[idx_v] <= init_val;
        end else if (relax_wr) begin
            dmem[p_v] <= DIST_W'(sum);
        end
        if (rd_issue) begin
            d_q_reg <= dmem[idx_v];
        end
    end

    // Counters, scan pipeline flags and visited set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg   <= '0;
            idx_reg     <= '0;
            pass_reg    <= '0;
            p_sel_reg   <= 1'b0;
            p_rel_reg   <= 1'b0;
            p_out_reg   <= 1'b0;
            found_reg   <= 1'b0;
            visited_reg <= '0;
        end else begin
            if (cmd.sweep) begin
                sweep_reg <= sweep_reg + AW'(1);
            end
            if (cmd.run_start || cmd.pass_start || cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.init_wr || rd_issue) begin
                idx_reg <= idx_reg + NW'(1);
            end
            if (cmd.run_start) begin
                pass_reg    <= '0;
                visited_reg <= '0;
            end else if (cmd.pick_commit) begin
                pass_reg <= pass_reg + NW'(1);
                if (found_reg) begin
                    visited_reg[pick_reg] <= 1'b1;
                end
            end
            if (cmd.pass_start) begin
                found_reg <= 1'b0;
            end else if (sel_take) begin
                found_reg <= 1'b1;
            end
            p_sel_reg <= cmd.sel_rd;
            p_rel_reg <= cmd.rel_rd;
            p_out_reg <= cmd.out_rd;
        end
    end

    // Payload of the scan: source, index in flight, current minimum
    always_ff @(posedge aclk) begin
        if (cmd.run_start) begin
            src_reg <= run_source;
        end
        if (rd_issue) begin
            p_idx_reg <= idx_reg;
        end
        if (sel_take) begin
            pick_reg <= p_v;
            best_reg <= d_q_reg;
        end
    end

    // Output register: load on a returned output read, drop on acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p_out_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_valid_reg && out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_out_reg) begin
            out_vertex_reg <= VERT_W'(p_idx_reg);
            out_dist_reg   <= d_q_reg;
            out_last_reg   <= p_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_vertex   = out_vertex_reg;
    assign out_distance = out_dist_reg;
    assign out_last     = out_last_reg;

    // Status to the controller
    assign sts.sweep_end = &sweep_reg;
    assign sts.idx_end   = (idx_reg == n_active);
    assign sts.pass_end  = (pass_reg == n_active);
    assign sts.pipe_busy = p_sel_reg | p_rel_reg;
    assign sts.out_busy  = p_out_reg | out_valid_reg;
    assign sts.found     = found_reg;
    assign sts.relax_ok  = found_reg && (best_reg < infinity);

endmodule
`default_nettype wire

[rtl/dense_shortest_path_engine_unit.sv]
// Top level of the shortest path engine: configuration registers, stream ports, controller and datapath.
//
//  channel  | ports                 | contents
//  ---------+-----------------------+------------------------------------------------
//  request  | s_tvalid/tready/...   | tuser=kind; tdata=row, col, weight, source
//  result   | m_tvalid/tready/...   | tdata=vertex, distance; tlast=last of run
//  config   | cfg_wr_en/index/data  | 0: vertex_count, 1: infinity; no read-back
//
// After reset a sweep writes no-edge into all MAX_VERTICES-rounded-up-squared
// matrix entries; no request is taken meanwhile. Weight writes are taken back to
// back while idle. A run over n vertices first initializes the distance table, then
// per pass scans and picks the minimum and, when the pick is reachable, relaxes its
// neighbors; after the last pass it reads out one result at a time, each waiting to
// be taken, and returns to idle; the scan is one distance-table and one matrix read
// per cycle. New requests wait until the last result is taken.
`default_nettype none
module dense_shortest_path_engine_unit #(
    parameter int MAX_VERTICES = dspe_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dspe_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [4:0] row, [9:5] col, [25:10] weight, [30:26] source, [31] zero
    input  wire logic [dspe_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [4:0] vertex, [20:5] distance, [23:21] zero
    output logic [dspe_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,
    input  wire logic                             cfg_wr_en,
    input  wire logic [dspe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dspe_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import dspe_pkg::*;

    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [VC_W-1:0]   vc_reg;
    logic [DIST_W-1:0] inf_reg;
    logic [NW-1:0]     n_active;
    dspe_cmd_t         cmd;
    dspe_sts_t         sts;
    logic [VERT_W-1:0] out_vertex;
    logic [DIST_W-1:0] out_distance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg  <= VC_RESET;
            inf_reg <= INF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_VERTEX_COUNT: vc_reg  <= cfg_wr_data[VC_W-1:0];
                REG_INFINITY:     inf_reg <= cfg_wr_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the vertex count into 1..MAX_VERTICES
    always_comb begin
        if (vc_reg == '0) begin
            n_active = NW'(1);
        end else if (32'(vc_reg) > 32'(MAX_VERTICES)) begin
            n_active = NW'(MAX_VERTICES);
        end else begin
            n_active = NW'(vc_reg);
        end
    end

    dspe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser[0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dspe_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .n_active     (n_active),
        .infinity     (inf_reg),
        .wr_row       (s_tdata[4:0]),
        .wr_col       (s_tdata[9:5]),
        .wr_weight    (s_tdata[25:10]),
        .run_source   (s_tdata[30:26]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_vertex   (out_vertex),
        .out_distance (out_distance),
        .out_last     (m_tlast)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {(M_TDATA_W - VERT_W - DIST_W)'(0), out_distance, out_vertex};

endmodule
`default_nettype wire
